[hw/rtl/ske_pkg.sv]
// ----------------------------------------------------------------------------
// ske_pkg
// Shared types, register codes, constants and helper functions of the SVM
// kernel evaluator.
// ----------------------------------------------------------------------------
package ske_pkg;

    localparam int DEF_MAX_DIMENSION = 1024;
    localparam int DEF_ELEMENT_WIDTH = 16;

    localparam int ACC_W      = 48;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_KERNEL_MODE  = 2'd0;
    localparam logic [1:0] REG_INV_SIGMA_SQ = 2'd1;
    localparam logic [1:0] REG_DEGREE       = 2'd2;

    localparam logic [1:0] MODE_LINEAR   = 2'd0;
    localparam logic [1:0] MODE_GAUSSIAN = 2'd1;
    localparam logic [1:0] MODE_POLY     = 2'd2;

    localparam logic [1:0]  RST_KERNEL_MODE  = MODE_LINEAR;
    localparam logic [23:0] RST_INV_SIGMA_SQ = 24'd65536;
    localparam logic [3:0]  RST_DEGREE       = 4'd2;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [31:0] MAG_CAP   = 32'hFFFF_FFFF;
    localparam logic [31:0] ONE_Q16   = 32'd65536;

    typedef struct packed {
        logic [1:0]  kernel_mode;
        logic [23:0] inv_sigma_sq;
        logic [3:0]  degree;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_ACC, ST_DRAIN, ST_PREP, ST_SLO, ST_SHI, ST_SSUM, ST_XQ, ST_KMUL, ST_K,
        ST_LNMUL, ST_RED, ST_FIX, ST_HMUL, ST_HSTEP, ST_GOUT, ST_PBASE, ST_PCHK,
        ST_PSTEP, ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE, MUL_SLO, MUL_SHI, MUL_LOG2E, MUL_LN2, MUL_HORNER, MUL_POLY
    } t_mul_sel;

    typedef enum logic [3:0] {
        OP_NONE, OP_PREP, OP_SLO, OP_SSUM, OP_XQ, OP_K, OP_RED, OP_FIX, OP_HSTEP,
        OP_PBASE, OP_PSTEP
    } t_dp_op;

    typedef enum logic [2:0] {
        RES_LINEAR, RES_ONE, RES_ZERO, RES_GAUSS, RES_POLY
    } t_res_sel;

    typedef struct packed {
        logic     accept;
        t_mul_sel mul_sel;
        t_dp_op   op;
        t_res_sel res_sel;
        logic     res_load;
    } t_cmd;

    typedef struct packed {
        logic acc_pos;
        logic xq_big;
        logic iter_zero;
    } t_stat;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_sat;

    // Taylor coefficients 1/n! in Q2.30.
    function automatic logic [31:0] inv_fact(input logic [3:0] n);
        logic [31:0] f;
        case (n)
            4'd0:    f = 32'd1073741824;
            4'd1:    f = 32'd1073741824;
            4'd2:    f = 32'd536870912;
            4'd3:    f = 32'd178956971;
            4'd4:    f = 32'd44739243;
            4'd5:    f = 32'd8947849;
            4'd6:    f = 32'd1491308;
            4'd7:    f = 32'd213044;
            4'd8:    f = 32'd26631;
            default: f = 32'd0;
        endcase
        return f;
    endfunction

    function automatic t_sat sat32(input logic signed [49:0] v);
        t_sat r;
        if (v > 50'sd2147483647) begin
            r.val = 32'h7FFF_FFFF;
            r.sat = 1'b1;
        end else if (v < -50'sd2147483648) begin
            r.val = 32'h8000_0000;
            r.sat = 1'b1;
        end else begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

[hw/rtl/ske_stream_if.sv]
// ----------------------------------------------------------------------------
// ske_stream_if
// Valid/ready channels of the kernel evaluator: element pairs in, kernel
// values out.
// ----------------------------------------------------------------------------
interface ske_in_if #(
    parameter int ELEMENT_WIDTH = ske_pkg::DEF_ELEMENT_WIDTH
);
    logic                            valid;
    logic                            ready;
    logic signed [ELEMENT_WIDTH-1:0] sample_element;
    logic signed [ELEMENT_WIDTH-1:0] reference_element;
    logic                            last_element;

    modport source (output valid, sample_element, reference_element, last_element,
                    input ready);
    modport sink   (input valid, sample_element, reference_element, last_element,
                    output ready);
endinterface

interface ske_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] kernel_value;
    logic               saturated;

    modport source (output valid, kernel_value, saturated, input ready);
    modport sink   (input valid, kernel_value, saturated, output ready);
endinterface

[hw/rtl/ske_regs.sv]
// ----------------------------------------------------------------------------
// ske_regs
// APB-style configuration registers: kernel mode, inverse sigma squared and
// polynomial degree.
// ----------------------------------------------------------------------------
module ske_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ske_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ske_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ske_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output ske_pkg::t_cfg                  o_cfg
);
    import ske_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel_mode  <= RST_KERNEL_MODE;
            r_cfg.inv_sigma_sq <= RST_INV_SIGMA_SQ;
            r_cfg.degree       <= RST_DEGREE;
        end else if (w_wr) begin
            case (w_idx)
                REG_KERNEL_MODE:  r_cfg.kernel_mode  <= pwdata[1:0];
                REG_INV_SIGMA_SQ: r_cfg.inv_sigma_sq <= pwdata[23:0];
                REG_DEGREE:       r_cfg.degree       <= pwdata[3:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_KERNEL_MODE:  prdata = {30'd0, r_cfg.kernel_mode};
            REG_INV_SIGMA_SQ: prdata = {8'd0, r_cfg.inv_sigma_sq};
            REG_DEGREE:       prdata = {28'd0, r_cfg.degree};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/ske_ctrl.sv]
// ----------------------------------------------------------------------------
// ske_ctrl
// Sequencer of the kernel evaluator: accumulation phase, the finishing
// sequence for each kernel mode, and the result hand-off.
// ----------------------------------------------------------------------------
module ske_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    input  logic           i_out_ready,
    input  logic [1:0]     i_mode,
    input  ske_pkg::t_stat i_stat,
    output ske_pkg::t_cmd  o_cmd,
    output logic           o_in_ready,
    output logic           o_out_valid
);
    import ske_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACC: begin
                if (i_in_valid && i_in_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: n_state = ST_PREP;
            ST_PREP: begin
                if (i_mode == MODE_POLY) begin
                    n_state = ST_SLO;
                end else if (i_mode == MODE_GAUSSIAN && i_stat.acc_pos) begin
                    n_state = ST_SLO;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_SLO:  n_state = ST_SHI;
            ST_SHI:  n_state = ST_SSUM;
            ST_SSUM: n_state = (i_mode == MODE_GAUSSIAN) ? ST_XQ : ST_PBASE;
            ST_XQ:   n_state = ST_KMUL;
            ST_KMUL: n_state = i_stat.xq_big ? ST_OUT : ST_K;
            ST_K:    n_state = ST_LNMUL;
            ST_LNMUL: n_state = ST_RED;
            ST_RED:  n_state = ST_FIX;
            ST_FIX:  n_state = ST_HMUL;
            ST_HMUL: n_state = ST_HSTEP;
            ST_HSTEP: n_state = i_stat.iter_zero ? ST_GOUT : ST_HMUL;
            ST_GOUT: n_state = ST_OUT;
            ST_PBASE: n_state = ST_PCHK;
            ST_PCHK: n_state = i_stat.iter_zero ? ST_OUT : ST_PSTEP;
            ST_PSTEP: n_state = ST_PCHK;
            ST_OUT: begin
                if (i_out_ready) n_state = ST_ACC;
            end
            default: n_state = ST_ACC;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_sel  = MUL_NONE;
        o_cmd.op       = OP_NONE;
        o_cmd.res_sel  = RES_LINEAR;
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        case (r_state)
            ST_ACC: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_PREP: begin
                o_cmd.op = OP_PREP;
                if (i_mode == MODE_GAUSSIAN && !i_stat.acc_pos) begin
                    o_cmd.res_sel  = RES_ONE;
                    o_cmd.res_load = 1'b1;
                end else if (i_mode != MODE_GAUSSIAN && i_mode != MODE_POLY) begin
                    o_cmd.res_sel  = RES_LINEAR;
                    o_cmd.res_load = 1'b1;
                end
            end
            ST_SLO:  o_cmd.mul_sel = MUL_SLO;
            ST_SHI: begin
                o_cmd.op      = OP_SLO;
                o_cmd.mul_sel = MUL_SHI;
            end
            ST_SSUM: o_cmd.op = OP_SSUM;
            ST_XQ:   o_cmd.op = OP_XQ;
            ST_KMUL: begin
                if (i_stat.xq_big) begin
                    o_cmd.res_sel  = RES_ZERO;
                    o_cmd.res_load = 1'b1;
                end else begin
                    o_cmd.mul_sel = MUL_LOG2E;
                end
            end
            ST_K:     o_cmd.op = OP_K;
            ST_LNMUL: o_cmd.mul_sel = MUL_LN2;
            ST_RED:   o_cmd.op = OP_RED;
            ST_FIX:   o_cmd.op = OP_FIX;
            ST_HMUL:  o_cmd.mul_sel = MUL_HORNER;
            ST_HSTEP: o_cmd.op = OP_HSTEP;
            ST_GOUT: begin
                o_cmd.res_sel  = RES_GAUSS;
                o_cmd.res_load = 1'b1;
            end
            ST_PBASE: o_cmd.op = OP_PBASE;
            ST_PCHK: begin
                if (i_stat.iter_zero) begin
                    o_cmd.res_sel  = RES_POLY;
                    o_cmd.res_load = 1'b1;
                end else begin
                    o_cmd.mul_sel = MUL_POLY;
                end
            end
            ST_PSTEP: o_cmd.op = OP_PSTEP;
            ST_OUT:   o_out_valid = 1'b1;
            default:  ;
        endcase
    end

endmodule

[hw/rtl/ske_datapath.sv]
// ----------------------------------------------------------------------------
// ske_datapath
// Accumulator, shared 32x32 multiplier and the registers of the finishing
// arithmetic (scaling, exponential range reduction, Horner loop, power loop).
// ----------------------------------------------------------------------------
module ske_datapath #(
    parameter int MAX_DIMENSION = ske_pkg::DEF_MAX_DIMENSION,
    parameter int ELEMENT_WIDTH = ske_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic signed [ELEMENT_WIDTH-1:0] i_sample,
    input  logic signed [ELEMENT_WIDTH-1:0] i_reference,
    input  ske_pkg::t_cfg                   i_cfg,
    input  ske_pkg::t_cmd                   i_cmd,
    output ske_pkg::t_stat                  o_stat,
    output logic signed [31:0]              o_kernel_value,
    output logic                            o_saturated
);
    import ske_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIMENSION + 1);
    localparam int TW    = (2 * ELEMENT_WIDTH + 2 > ACC_W) ? 2 * ELEMENT_WIDTH + 2 : ACC_W;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [TW-1:0]    T_MAX   = TW'(ACC_MAX);
    localparam logic signed [TW-1:0]    T_MIN   = TW'(ACC_MIN);

    // Accumulation: the term is registered at accept and added in the following cycle.
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_term;
    logic                    r_tv;
    logic [CNT_W-1:0]        r_cnt;

    logic signed [ELEMENT_WIDTH:0]   w_diff;
    logic        [ELEMENT_WIDTH:0]   w_dmag;
    logic        [TW-1:0]            w_sq;
    logic signed [TW-1:0]            w_prd;
    logic signed [ACC_W-1:0]         w_term;
    logic signed [ACC_W:0]           w_sum;
    logic signed [ACC_W-1:0]         w_sum_sat;

    assign w_diff = {i_sample[ELEMENT_WIDTH-1], i_sample}
                  - {i_reference[ELEMENT_WIDTH-1], i_reference};
    assign w_dmag = w_diff[ELEMENT_WIDTH] ? $unsigned(-w_diff) : $unsigned(w_diff);
    assign w_sq   = TW'(w_dmag) * TW'(w_dmag);
    assign w_prd  = TW'(i_sample) * TW'(i_reference);

    always_comb begin
        if (i_cfg.kernel_mode == MODE_GAUSSIAN) begin
            w_term = (w_sq > $unsigned(T_MAX)) ? ACC_MAX : $signed(w_sq[ACC_W-1:0]);
        end else if (w_prd > T_MAX) begin
            w_term = ACC_MAX;
        end else if (w_prd < T_MIN) begin
            w_term = ACC_MIN;
        end else begin
            w_term = w_prd[ACC_W-1:0];
        end
    end

    assign w_sum = {r_acc[ACC_W-1], r_acc} + {r_term[ACC_W-1], r_term};
    always_comb begin
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_sum_sat = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            w_sum_sat = w_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_tv  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_tv <= 1'b0;
            if (i_cmd.op == OP_PREP) begin
                r_acc <= '0;
                r_cnt <= '0;
            end else begin
                if (r_tv) r_acc <= w_sum_sat;
                if (i_cmd.accept && r_cnt < CNT_W'(MAX_DIMENSION)) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_tv  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_term <= w_term;
    end

    // Rounded magnitude of the accumulator, Q.16.
    logic [ACC_W-1:0] w_amag;
    logic [ACC_W:0]   w_arnd;
    logic [39:0]      w_m16;
    logic signed [49:0] w_lin;

    assign w_amag = r_acc[ACC_W-1] ? $unsigned(-r_acc) : $unsigned(r_acc);
    assign w_arnd = {1'b0, w_amag} + (ACC_W+1)'(128);
    assign w_m16  = w_arnd[47:8];
    assign w_lin  = r_acc[ACC_W-1] ? -$signed({10'd0, w_m16}) : $signed({10'd0, w_m16});

    // Finishing registers.
    logic [39:0] r_m16;
    logic        r_neg;
    logic [63:0] r_prod;
    logic [63:0] r_scl;
    logic [20:0] r_xq;
    logic        r_xbig;
    logic [5:0]  r_k;
    logic signed [37:0] r_red;
    logic [31:0] r_r;
    logic [31:0] r_p;
    logic [3:0]  r_iter;
    logic [31:0] r_mr;
    logic [31:0] r_mb;
    logic        r_pneg;
    logic signed [31:0] r_kval;
    logic        r_sat;

    logic [31:0] w_ma;
    logic [31:0] w_mb;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SLO: begin
                w_ma = {8'd0, r_m16[23:0]};
                w_mb = {8'd0, i_cfg.inv_sigma_sq};
            end
            MUL_SHI: begin
                w_ma = {16'd0, r_m16[39:24]};
                w_mb = {8'd0, i_cfg.inv_sigma_sq};
            end
            MUL_LOG2E: begin
                w_ma = {11'd0, r_xq};
                w_mb = {1'b0, LOG2E_Q30};
            end
            MUL_LN2: begin
                w_ma = {26'd0, r_k};
                w_mb = {2'd0, LN2_Q30};
            end
            MUL_HORNER: begin
                w_ma = r_r;
                w_mb = r_p;
            end
            MUL_POLY: begin
                w_ma = r_mr;
                w_mb = r_mb;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    logic [64:0] w_xs;
    logic [47:0] w_xqf;
    assign w_xs  = {1'b0, r_scl} + 65'd65536;
    assign w_xqf = w_xs[64:17];

    // Range-reduction corrections, in the same order as the remainder checks.
    logic signed [37:0] w_r1;
    logic signed [37:0] w_r2;
    logic signed [37:0] w_r3;
    logic [5:0]         w_k1;
    logic [5:0]         w_k3;
    localparam logic signed [37:0] LN2_S = $signed({8'd0, LN2_Q30});

    always_comb begin
        w_r1 = r_red;
        w_k1 = r_k;
        if (r_red < 0 && r_k != 6'd0) begin
            w_r1 = r_red + LN2_S;
            w_k1 = r_k - 1'b1;
        end
        w_r2 = (w_r1 < 0) ? 38'sd0 : w_r1;
        w_r3 = w_r2;
        w_k3 = w_k1;
        if (w_r2 >= LN2_S) begin
            w_r3 = w_r2 - LN2_S;
            w_k3 = w_k1 + 1'b1;
        end
    end

    logic signed [34:0] w_q;
    assign w_q = $signed({3'd0, inv_fact(r_iter)}) - $signed({1'b0, r_prod[63:30]});

    // Polynomial base 1 + s*dot, as sign and capped magnitude.
    logic [64:0]        w_bs;
    logic signed [49:0] w_bq;
    logic signed [49:0] w_base;
    logic        [49:0] w_bmag;
    assign w_bs   = {1'b0, r_scl} + 65'd32768;
    assign w_bq   = r_neg ? -$signed({1'b0, w_bs[64:16]}) : $signed({1'b0, w_bs[64:16]});
    assign w_base = w_bq + 50'sd65536;
    assign w_bmag = w_base[49] ? $unsigned(-w_base) : $unsigned(w_base);

    logic [64:0] w_ps;
    assign w_ps = {1'b0, r_prod} + 65'd32768;

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (i_cmd.op)
            OP_PREP: begin
                r_m16 <= w_m16;
                r_neg <= r_acc[ACC_W-1];
            end
            OP_SLO:  r_scl <= r_prod;
            OP_SSUM: r_scl <= r_scl + {r_prod[39:0], 24'd0};
            OP_XQ: begin
                r_xq   <= w_xqf[20:0];
                r_xbig <= |w_xqf[47:21];
            end
            OP_K:   r_k <= r_prod[51:46];
            OP_RED: r_red <= $signed({3'd0, r_xq, 14'd0}) - $signed({1'b0, r_prod[36:0]});
            OP_FIX: begin
                r_r    <= w_r3[31:0];
                r_k    <= w_k3;
                r_p    <= inv_fact(4'd8);
                r_iter <= 4'd7;
            end
            OP_HSTEP: begin
                r_p    <= w_q[34] ? 32'd0 : w_q[31:0];
                r_iter <= r_iter - 1'b1;
            end
            OP_PBASE: begin
                r_mb   <= (w_bmag > 50'(MAG_CAP)) ? MAG_CAP : w_bmag[31:0];
                r_pneg <= w_base[49] & i_cfg.degree[0];
                r_mr   <= ONE_Q16;
                r_iter <= i_cfg.degree;
            end
            OP_PSTEP: begin
                r_mr   <= (w_ps[64:16] > 49'(MAG_CAP)) ? MAG_CAP : w_ps[47:16];
                r_iter <= r_iter - 1'b1;
            end
            default: ;
        endcase
    end

    // Result selection and saturation into Q16.16.
    logic [63:0]        w_gsum;
    logic [63:0]        w_gval;
    logic signed [49:0] w_res;
    t_sat               w_sat;

    assign w_gsum = {32'd0, r_p} + (64'd1 << (7'(r_k) + 7'd13));
    assign w_gval = w_gsum >> (7'(r_k) + 7'd14);

    always_comb begin
        case (i_cmd.res_sel)
            RES_LINEAR: w_res = w_lin;
            RES_ONE:    w_res = 50'sd65536;
            RES_ZERO:   w_res = 50'sd0;
            RES_GAUSS:  w_res = $signed({1'b0, w_gval[48:0]});
            RES_POLY:   w_res = r_pneg ? -$signed({18'd0, r_mr}) : $signed({18'd0, r_mr});
            default:    w_res = 50'sd0;
        endcase
        w_sat = sat32(w_res);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_kval <= w_sat.val;
            r_sat  <= w_sat.sat;
        end
    end

    assign o_stat.acc_pos   = !r_acc[ACC_W-1] && (r_acc != '0);
    assign o_stat.xq_big    = r_xbig;
    assign o_stat.iter_zero = (r_iter == 4'd0);
    assign o_kernel_value   = r_kval;
    assign o_saturated      = r_sat;

endmodule

[hw/rtl/svm_kernel_evaluator_core.sv]
// ----------------------------------------------------------------------------
// svm_kernel_evaluator_core
// SVM kernel evaluator: linear, gaussian and polynomial kernels over streamed
// element pairs, with an APB-style configuration port.
// ----------------------------------------------------------------------------
// Element pairs are taken one per cycle while a vector accumulates. After the
// item flagged as last, no new item is taken until the kernel value has been
// handed off; the finishing sequence runs on one shared 32x32 multiplier with
// a registered product. The result is loaded once the accumulator has drained
// in linear mode (and in gaussian mode with a non-positive sum), after
// scaling, range reduction and an 8-step Horner loop in gaussian mode, and
// after one multiply pass per power step in polynomial mode.
// The next vector may start in the cycle after the result is taken.
module svm_kernel_evaluator_core #(
    parameter int MAX_DIMENSION = ske_pkg::DEF_MAX_DIMENSION,
    parameter int ELEMENT_WIDTH = ske_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ske_in_if.sink                         i_in,
    ske_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ske_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ske_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ske_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ske_pkg::*;

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    ske_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ske_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_element),
        .i_out_ready (o_out.ready),
        .i_mode      (w_cfg.kernel_mode),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    ske_datapath #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample       (i_in.sample_element),
        .i_reference    (i_in.reference_element),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_kernel_value (o_out.kernel_value),
        .o_saturated    (o_out.saturated)
    );

    // A pending result blocks new items.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("item taken while a result is pending");

    a_last_stops_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_element) |=> !i_in.ready)
        else $error("item taken right after the last item of a vector");

    a_handoff_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> (i_in.ready && !o_out.valid))
        else $error("input not reopened after result hand-off");

    a_gauss_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && w_cfg.kernel_mode == MODE_GAUSSIAN) |-> !o_out.saturated)
        else $error("gaussian result flagged as saturated");

endmodule
